// ===== design/swv_pkg.sv =====
`default_nettype none
package swv_pkg;

  localparam int WINDOW     = 16;
  localparam int SAMPLE_W   = 8;
  localparam int VAR_W      = 15;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int ACC_W      = SQ_W + CNT_W;
  localparam int DIV_W      = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV1,
    S_SQ,
    S_DIV2,
    S_OUT
  } swv_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } swv_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } swv_div_rsp_t;

endpackage
`default_nettype wire

// ===== design/swv_window.sv =====
`default_nettype none
module swv_window (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic signed [swv_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic        [swv_pkg::IDX_W-1:0]   rd_addr,
  output logic signed      [swv_pkg::SAMPLE_W-1:0] rd_data,
  output logic             [swv_pkg::CNT_W-1:0]   count
);

  logic signed [swv_pkg::SAMPLE_W-1:0] mem [swv_pkg::WINDOW];
  logic        [swv_pkg::IDX_W-1:0]    ptr;

  // circular buffer: the oldest entry is overwritten once full, order is irrelevant to the sums
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      count <= '0;
    end else if (wr_en) begin
      if (ptr == swv_pkg::IDX_W'(swv_pkg::WINDOW - 1)) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + 1'b1;
      end
      if (count != swv_pkg::CNT_W'(swv_pkg::WINDOW)) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/swv_div.sv =====
`default_nettype none
module swv_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire swv_pkg::swv_div_req_t req,
  output swv_pkg::swv_div_rsp_t      rsp
);

  logic                           busy;
  logic                           done;
  logic [swv_pkg::DIV_CNT_W-1:0]  step;
  logic [swv_pkg::DIV_W-1:0]      quo;
  logic [swv_pkg::DIV_W-1:0]      quo_next;
  logic [swv_pkg::CNT_W-1:0]      rem;
  logic [swv_pkg::CNT_W-1:0]      rem_next;
  logic [swv_pkg::CNT_W-1:0]      dsr;
  logic [swv_pkg::CNT_W:0]        rem_sh;
  logic                           ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, quo[swv_pkg::DIV_W-1]};
    ge       = (rem_sh >= {1'b0, dsr});
    rem_next = ge ? swv_pkg::CNT_W'(rem_sh - {1'b0, dsr}) : rem_sh[swv_pkg::CNT_W-1:0];
    quo_next = {quo[swv_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= swv_pkg::DIV_CNT_W'(swv_pkg::DIV_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ===== design/sliding_window_variance_top.sv =====
// From sample transfer to result valid, the block makes two serial walks over the n filled
// entries (n being the fill count after the transfer) of the single-read-port window store
// and two passes through the shared one-bit-per-cycle divider.
// A new sample is taken only once the previous one has passed both walks and both divisions
// and its result has entered the output register; a finished result may wait in the output
// register while the next sample is taken. Reset clears the fill count, write pointer,
// sequencer and output valid; window contents are not cleared.
`default_nettype none
module sliding_window_variance_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output logic                                    sample_stall,
  input  wire logic signed [swv_pkg::SAMPLE_W-1:0] sample,
  output logic                                    variance_valid,
  input  wire logic                               variance_stall,
  output logic             [swv_pkg::VAR_W-1:0]   variance
);

  swv_pkg::swv_state_t               state;
  swv_pkg::swv_state_t               state_next;
  logic [swv_pkg::CNT_W-1:0]         idx;
  logic [swv_pkg::CNT_W-1:0]         idx_next;
  logic signed [swv_pkg::SUM_W-1:0]  sum;
  logic signed [swv_pkg::SUM_W-1:0]  sum_next;
  logic [swv_pkg::SUM_W-1:0]         sum_abs;
  logic [swv_pkg::ACC_W-1:0]         acc;
  logic [swv_pkg::ACC_W-1:0]         acc_next;
  logic signed [swv_pkg::SAMPLE_W-1:0] mean;
  logic signed [swv_pkg::SAMPLE_W-1:0] mean_next;
  logic [swv_pkg::SAMPLE_W-1:0]      mean_mag;
  logic                              rd_vld;
  logic                              rd_vld_next;
  logic [swv_pkg::SQ_W-1:0]          sq;
  logic                              sq_vld;
  logic                              sq_vld_next;
  logic signed [swv_pkg::DIFF_W-1:0] diff;
  logic signed [2*swv_pkg::DIFF_W-1:0] sq_full;
  logic                              variance_valid_next;
  logic [swv_pkg::VAR_W-1:0]         variance_next;
  logic                              take;
  logic signed [swv_pkg::SAMPLE_W-1:0] rd_data;
  logic [swv_pkg::CNT_W-1:0]         win_count;
  swv_pkg::swv_div_req_t             div_req;
  swv_pkg::swv_div_rsp_t             div_rsp;

  assign sample_stall = rst || (state != swv_pkg::S_IDLE);
  assign take         = sample_valid && !sample_stall;

  swv_window u_window (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (sample),
    .rd_addr (idx[swv_pkg::IDX_W-1:0]),
    .rd_data (rd_data),
    .count   (win_count)
  );

  swv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sum_abs  = sum[swv_pkg::SUM_W-1] ? (~sum + swv_pkg::SUM_W'(1)) : sum;
  assign mean_mag = div_rsp.quotient[swv_pkg::SAMPLE_W-1:0];
  assign diff     = {rd_data[swv_pkg::SAMPLE_W-1], rd_data} - {mean[swv_pkg::SAMPLE_W-1], mean};
  assign sq_full  = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= swv_pkg::S_IDLE;
      rd_vld         <= 1'b0;
      sq_vld         <= 1'b0;
      variance_valid <= 1'b0;
    end else begin
      state          <= state_next;
      rd_vld         <= rd_vld_next;
      sq_vld         <= sq_vld_next;
      variance_valid <= variance_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    sum      <= sum_next;
    acc      <= acc_next;
    mean     <= mean_next;
    sq       <= sq_full[swv_pkg::SQ_W-1:0];
    variance <= variance_next;
  end

  always_comb begin
    state_next          = state;
    idx_next            = idx;
    sum_next            = sum;
    acc_next            = acc;
    mean_next           = mean;
    rd_vld_next         = 1'b0;
    sq_vld_next         = 1'b0;
    variance_valid_next = variance_valid && variance_stall;
    variance_next       = variance;
    div_req.start       = 1'b0;
    div_req.dividend    = acc;
    div_req.divisor     = win_count;

    case (state)
      swv_pkg::S_IDLE: begin
        if (take) begin
          idx_next   = '0;
          sum_next   = '0;
          state_next = swv_pkg::S_SUM;
        end
      end
      swv_pkg::S_SUM: begin
        if (idx != win_count) begin
          idx_next    = idx + 1'b1;
          rd_vld_next = 1'b1;
        end
        if (rd_vld) begin
          sum_next = sum + {{(swv_pkg::SUM_W - swv_pkg::SAMPLE_W){rd_data[swv_pkg::SAMPLE_W-1]}},
                            rd_data};
        end else if (idx == win_count) begin
          // magnitude divided, sign restored afterwards for truncation toward zero
          div_req.start    = 1'b1;
          div_req.dividend = {{(swv_pkg::DIV_W - swv_pkg::SUM_W){1'b0}}, sum_abs};
          state_next       = swv_pkg::S_DIV1;
        end
      end
      swv_pkg::S_DIV1: begin
        if (div_rsp.done) begin
          mean_next  = sum[swv_pkg::SUM_W-1] ? (~mean_mag + swv_pkg::SAMPLE_W'(1)) : mean_mag;
          idx_next   = '0;
          acc_next   = '0;
          state_next = swv_pkg::S_SQ;
        end
      end
      swv_pkg::S_SQ: begin
        if (idx != win_count) begin
          idx_next    = idx + 1'b1;
          rd_vld_next = 1'b1;
        end
        sq_vld_next = rd_vld;
        if (sq_vld) begin
          acc_next = acc + swv_pkg::ACC_W'(sq);
        end
        if (idx == win_count && !rd_vld && !sq_vld) begin
          div_req.start = 1'b1;
          state_next    = swv_pkg::S_DIV2;
        end
      end
      swv_pkg::S_DIV2: begin
        if (div_rsp.done) begin
          acc_next   = div_rsp.quotient;
          state_next = swv_pkg::S_OUT;
        end
      end
      swv_pkg::S_OUT: begin
        if (!variance_valid || !variance_stall) begin
          variance_valid_next = 1'b1;
          variance_next       = acc[swv_pkg::VAR_W-1:0];
          state_next          = swv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swv_pkg::S_IDLE;
      end
    endcase
  end

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == swv_pkg::S_DIV1 || state == swv_pkg::S_DIV2))
    else $error("divider finished outside a division state");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    win_count <= swv_pkg::CNT_W'(swv_pkg::WINDOW))
    else $error("fill count beyond window");

  a_mean_stable: assert property (@(posedge clk) disable iff (rst)
    (state == swv_pkg::S_SQ && $past(state) == swv_pkg::S_SQ) |-> $stable(mean))
    else $error("mean changed during deviation pass");

  a_variance_range: assert property (@(posedge clk) disable iff (rst)
    variance_valid |-> (variance <= swv_pkg::VAR_W'(16384)))
    else $error("variance out of range");

endmodule
`default_nettype wire
